// ===== src/acm_pkg.sv =====
// acm_pkg: types, constants and AES-128 round functions for the CMAC tag engine.
// No dependencies; used by acm_front, acm_queue, acm_back and the top module.
package acm_pkg;

  localparam int unsigned BLK_W   = 128;
  localparam int unsigned Q_DEPTH = 2;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [7:0]  GF_POLY  = 8'h87;
  localparam logic [3:0]  LAST_RND = 4'd10;

  // configuration register indexes
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_RUN
  } bk_state_t;

  typedef enum logic [1:0] {
    OP_DER,
    OP_CHN,
    OP_FIN
  } op_t;

  // one unit of work handed from the byte gatherer to the cipher sequencer
  typedef struct packed {
    logic             der;       // derive subkeys first
    logic             chn;       // chain a full pending block
    logic [BLK_W-1:0] chn_blk;
    logic             fin;       // final block (already padded)
    logic             fin_full;  // complete block: use K1, else K2
    logic [BLK_W-1:0] fin_blk;
  } job_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // next round key from the current one
  function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] rk,
                                                 input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, tmp;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    tmp = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ tmp;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey
  function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                  input logic [BLK_W-1:0] rk,
                                                  input logic last);
    logic [7:0] sb [16];
    logic [7:0] t  [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BLK_W-1:0] r;
    for (int i = 0; i < 16; i++) begin
      sb[i] = s[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = SBOX[sb[i + 4*((c+i) % 4)]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = t[i];
    end
    aes_round = r ^ rk;
  endfunction

  // doubling in GF(2^128)
  function automatic logic [BLK_W-1:0] gf_dbl(input logic [BLK_W-1:0] x);
    gf_dbl = {x[BLK_W-2:0], 1'b0} ^ (x[BLK_W-1] ? {{(BLK_W-8){1'b0}}, GF_POLY}
                                                : {BLK_W{1'b0}});
  endfunction

endpackage

// ===== src/acm_if.sv =====
// acm_in_if / acm_out_if: valid/ready channels of the CMAC tag engine.
// Depends on nothing.
interface acm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface acm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mic;
  modport source (output valid, output mic, input ready);
  modport sink   (input valid, input mic, output ready);
endinterface

// ===== src/acm_front.sv =====
// acm_front: byte gatherer; builds 16-byte blocks, pads the final one and
// emits jobs. Depends on acm_pkg and acm_in_if.
module acm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          key_wr,
  acm_in_if.sink        in_chan,
  input  logic          q_full,
  output logic          q_push,
  output acm_pkg::job_t q_job
);
  import acm_pkg::*;

  logic [BLK_W-1:0] buf_r, buf_nxt, nb;
  logic [4:0]       cnt_r, cnt_nxt, ncnt;
  logic             sub_rdy_r, sub_rdy_nxt;
  logic [3:0]       pos;
  logic             acc;

  assign in_chan.ready = !q_full;
  assign acc = in_chan.valid && in_chan.ready;

  always_comb begin
    // a held sixteenth byte means the buffer restarts with this byte
    pos = cnt_r[4] ? 4'd0 : cnt_r[3:0];
    nb  = cnt_r[4] ? {BLK_W{1'b0}} : buf_r;
    nb[{~pos, 3'b000} +: 8] = in_chan.data_byte;
    ncnt = {1'b0, pos} + 5'd1;

    q_job.der      = !sub_rdy_r;
    q_job.chn      = cnt_r[4];
    q_job.chn_blk  = buf_r;
    q_job.fin      = in_chan.last_byte;
    q_job.fin_full = ncnt[4];
    q_job.fin_blk  = nb;
    if (!ncnt[4]) begin
      q_job.fin_blk[{~ncnt[3:0], 3'b000} +: 8] = PAD_BYTE;
    end
    q_push = acc && (q_job.der || q_job.chn || q_job.fin);

    buf_nxt     = buf_r;
    cnt_nxt     = cnt_r;
    sub_rdy_nxt = sub_rdy_r;
    if (acc) begin
      sub_rdy_nxt = 1'b1;
      if (in_chan.last_byte) begin
        buf_nxt = '0;
        cnt_nxt = '0;
      end else begin
        buf_nxt = nb;
        cnt_nxt = ncnt;
      end
    end
    if (key_wr) begin
      sub_rdy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r     <= '0;
      cnt_r     <= '0;
      sub_rdy_r <= 1'b0;
    end else begin
      buf_r     <= buf_nxt;
      cnt_r     <= cnt_nxt;
      sub_rdy_r <= sub_rdy_nxt;
    end
  end
endmodule

// ===== src/acm_queue.sv =====
// acm_queue: two-entry job queue between gatherer and cipher sequencer.
// Depends on acm_pkg.
module acm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  acm_pkg::job_t wr_job,
  input  logic          pop,
  output acm_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);
  import acm_pkg::*;

  job_t       mem [Q_DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == 2'(Q_DEPTH));
  assign empty  = (cnt_r == 2'd0);
  assign rd_job = mem[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

// ===== src/acm_back.sv =====
// acm_back: cipher sequencer; one AES-128 round per cycle, runs subkey
// derivation, CBC chaining and the final tag. Depends on acm_pkg, acm_out_if.
module acm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [127:0]     key,
  input  logic             q_empty,
  input  acm_pkg::job_t    q_job,
  output logic             q_pop,
  acm_out_if.source        out_chan
);
  import acm_pkg::*;

  bk_state_t        st_r, st_nxt;
  op_t              op_r, op_nxt;
  job_t             job_r, job_nxt;
  logic [BLK_W-1:0] s_r, s_nxt, rk_r, rk_nxt, chain_r, chain_nxt;
  logic [BLK_W-1:0] k1_r, k1_nxt, k2_r, k2_nxt;
  logic [7:0]       rcon_r, rcon_nxt;
  logic [3:0]       rnd_r, rnd_nxt;
  logic             ov_r, ov_nxt;
  logic [31:0]      mic_r, mic_nxt;
  logic [BLK_W-1:0] rk_step, s_step, l_val;
  logic             last_rnd;

  assign out_chan.valid = ov_r;
  assign out_chan.mic   = mic_r;

  always_comb begin
    rk_step  = key_step(rk_r, rcon_r);
    last_rnd = (rnd_r == LAST_RND);
    s_step   = aes_round(s_r, rk_step, last_rnd);
    l_val    = gf_dbl(s_step);

    st_nxt    = st_r;
    op_nxt    = op_r;
    job_nxt   = job_r;
    s_nxt     = s_r;
    rk_nxt    = rk_r;
    rcon_nxt  = rcon_r;
    rnd_nxt   = rnd_r;
    chain_nxt = chain_r;
    k1_nxt    = k1_r;
    k2_nxt    = k2_r;
    mic_nxt   = mic_r;
    ov_nxt    = ov_r && !out_chan.ready;
    q_pop     = 1'b0;

    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          st_nxt  = BK_LOAD;
        end
      end
      BK_LOAD: begin
        rk_nxt   = key;
        rcon_nxt = 8'h01;
        rnd_nxt  = 4'd1;
        st_nxt   = BK_RUN;
        priority if (job_r.der) begin
          op_nxt = OP_DER;
          s_nxt  = key;
        end else if (job_r.chn) begin
          op_nxt = OP_CHN;
          s_nxt  = chain_r ^ job_r.chn_blk ^ key;
        end else begin
          op_nxt = OP_FIN;
          s_nxt  = chain_r ^ job_r.fin_blk ^ (job_r.fin_full ? k1_r : k2_r) ^ key;
        end
      end
      BK_RUN: begin
        if (!last_rnd) begin
          s_nxt    = s_step;
          rk_nxt   = rk_step;
          rcon_nxt = xtime(rcon_r);
          rnd_nxt  = rnd_r + 4'd1;
        end else begin
          unique case (op_r)
            OP_DER: begin
              k1_nxt      = l_val;
              k2_nxt      = gf_dbl(l_val);
              job_nxt.der = 1'b0;
            end
            OP_CHN: begin
              chain_nxt   = s_step;
              job_nxt.chn = 1'b0;
            end
            OP_FIN: begin
              // wait here until the output register is free
              if (!ov_r || out_chan.ready) begin
                mic_nxt     = s_step[127:96];
                ov_nxt      = 1'b1;
                chain_nxt   = '0;
                job_nxt.fin = 1'b0;
              end
            end
            default: ;
          endcase
          if (job_nxt.der || job_nxt.chn || job_nxt.fin) begin
            st_nxt = (op_r == OP_FIN && job_nxt.fin) ? BK_RUN : BK_LOAD;
          end else begin
            st_nxt = BK_IDLE;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    op_r   <= op_nxt;
    s_r    <= s_nxt;
    rk_r   <= rk_nxt;
    rcon_r <= rcon_nxt;
    rnd_r  <= rnd_nxt;
    k1_r   <= k1_nxt;
    k2_r   <= k2_nxt;
    mic_r  <= mic_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      ov_r    <= 1'b0;
      chain_r <= '0;
    end else begin
      st_r    <= st_nxt;
      ov_r    <= ov_nxt;
      chain_r <= chain_nxt;
    end
  end
endmodule

// ===== src/aes_cmac_message_code.sv =====
// AES-128 CMAC tag engine, first 32 tag bits per message.
// in_chan: one message byte per transfer, last_byte marks the end of a
//   message (a message has at least one byte). out_chan: one mic per message.
// cfg_*: cfg_index 0 writes key bytes 0..7, index 1 key bytes 8..15; write
//   only while idle. The next byte after a key write first derives K1/K2.
// Throughput: one byte per cycle sustained for messages of 16 bytes or more.
//   The cipher sequencer runs one AES round per cycle, the final tag round
//   waiting on a busy output register; a two-entry job queue decouples it
//   from the byte gatherer; in_chan.ready drops only when the queue is full.
// Tag path: the last byte's job is queued and, once the sequencer is free,
//   picked up; subkey derivation, a flushed held full block and the final
//   block each take a load state and the rounds, the mic registered last.
// Reset (synchronous, rst_n low): key zero, message state cleared, subkeys
//   marked stale, queue empty, no result pending.
// A stalled receiver holds the mic in the output register; the sequencer
//   waits on the final round and the queue fills before input is stalled.
module aes_cmac_message_code (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  acm_in_if.sink      in_chan,
  acm_out_if.source   out_chan
);
  import acm_pkg::*;

  logic [63:0] key_hi_r, key_hi_nxt, key_lo_r, key_lo_nxt;
  logic        q_push, q_pop, q_full, q_empty;
  job_t        wr_job, rd_job;

  always_comb begin
    key_hi_nxt = key_hi_r;
    key_lo_nxt = key_lo_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_HIGH: key_hi_nxt = cfg_data;
        CFG_KEY_LOW:  key_lo_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else begin
      key_hi_r <= key_hi_nxt;
      key_lo_r <= key_lo_nxt;
    end
  end

  acm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .key_wr (cfg_we),
    .in_chan(in_chan),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (wr_job)
  );

  acm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wr_job(wr_job),
    .pop   (q_pop),
    .rd_job(rd_job),
    .full  (q_full),
    .empty (q_empty)
  );

  acm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .key     ({key_hi_r, key_lo_r}),
    .q_empty (q_empty),
    .q_job   (rd_job),
    .q_pop   (q_pop),
    .out_chan(out_chan)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("job queue underflow");
  a_job_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (wr_job.der || wr_job.chn || wr_job.fin))
    else $error("empty job pushed");
`endif
endmodule
